@@ hdl/lcar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types, widths and constants of the load cell ADC reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_AVERAGE   = 255;
    localparam int COUNT_BITS    = 8;
    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int SCALE_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int WEIGHT_BITS   = 32;
    localparam int PROD_BITS     = SAMPLE_BITS + SCALE_BITS;
    localparam int QUOT_BITS     = PROD_BITS - FRAC_BITS;
    localparam int EDGE_BITS     = $clog2(SAMPLE_BITS + 1);
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
    localparam int MUL_CNT_BITS  = $clog2(SAMPLE_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_USED_BITS = 3 * 1 + 2 * SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_SELECT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AVERAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_SCALE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POWER_DOWN    = 2'd3;

    localparam logic [1:0] GAIN_A128 = 2'd0;
    localparam logic [1:0] GAIN_A64  = 2'd1;
    localparam logic [1:0] GAIN_B32  = 2'd2;

    localparam logic [COUNT_BITS-1:0]  AVERAGE_COUNT_RST = 8'd10;
    localparam logic [COUNT_BITS-1:0]  AVERAGE_MAX       = COUNT_BITS'(MAX_AVERAGE);
    localparam logic [SCALE_BITS-1:0]  INVERSE_SCALE_RST = 32'h0001_0000;
    localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP         = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [QUOT_BITS-1:0]   Q_POS_MAX         = QUOT_BITS'(64'h7FFF_FFFF);
    localparam logic [QUOT_BITS-1:0]   Q_NEG_MAX         = QUOT_BITS'(64'h8000_0000);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_GAIN
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL
    } t_state;

    typedef struct packed {
        logic                   sck;
        logic                   done;
        logic [SAMPLE_BITS-1:0] sample;
    } t_link_evt;

    function automatic logic [EDGE_BITS-1:0] gain_pulses(input logic [1:0] gain);
        logic [EDGE_BITS-1:0] pulses;
        case (gain)
            GAIN_A128: pulses = EDGE_BITS'(1);
            GAIN_A64:  pulses = EDGE_BITS'(3);
            GAIN_B32:  pulses = EDGE_BITS'(2);
            default:   pulses = EDGE_BITS'(1);
        endcase
        return pulses;
    endfunction

endpackage

@@ hdl/lcar_link.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_link
// Serial clock sequencer: waits for data-out low, shifts in the sample bit
// by bit and gives the gain pulses.
// ----------------------------------------------------------------------------
module lcar_link (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_dout,
    input  logic                 i_power_down,
    input  logic [1:0]           i_gain,
    output lcar_pkg::t_link_evt  o_evt
);

    lcar_pkg::t_phase                     r_phase, n_phase;
    logic [lcar_pkg::EDGE_BITS-1:0]       r_edge,  n_edge;
    logic                                 r_high,  n_high;
    logic [lcar_pkg::SAMPLE_BITS-1:0]     r_shift, n_shift;
    logic [lcar_pkg::EDGE_BITS-1:0]       w_cnt;

    always_comb begin
        n_phase      = r_phase;
        n_edge       = r_edge;
        n_high       = r_high;
        n_shift      = r_shift;
        o_evt.sck    = 1'b0;
        o_evt.done   = 1'b0;
        o_evt.sample = r_shift ^ lcar_pkg::SIGN_FLIP;
        w_cnt        = r_edge + lcar_pkg::EDGE_BITS'(1);
        if (i_power_down) begin
            o_evt.sck = 1'b1;
            n_phase   = lcar_pkg::PH_IDLE;
            n_edge    = '0;
            n_high    = 1'b0;
            n_shift   = '0;
        end else begin
            case (r_phase)
                lcar_pkg::PH_IDLE: begin
                    if (!i_dout) begin
                        n_phase = lcar_pkg::PH_DATA;
                        n_edge  = '0;
                        n_high  = 1'b0;
                        n_shift = '0;
                    end
                end
                lcar_pkg::PH_DATA: begin
                    if (!r_high) begin
                        o_evt.sck = 1'b1;
                        n_shift   = {r_shift[lcar_pkg::SAMPLE_BITS-2:0], i_dout};
                        n_high    = 1'b1;
                    end else begin
                        n_high = 1'b0;
                        n_edge = w_cnt;
                        if (w_cnt >= lcar_pkg::EDGE_BITS'(lcar_pkg::SAMPLE_BITS)) begin
                            n_phase = lcar_pkg::PH_GAIN;
                            n_edge  = '0;
                        end
                    end
                end
                lcar_pkg::PH_GAIN: begin
                    if (!r_high) begin
                        o_evt.sck = 1'b1;
                        n_high    = 1'b1;
                    end else begin
                        n_high = 1'b0;
                        n_edge = w_cnt;
                        if (w_cnt >= lcar_pkg::gain_pulses(i_gain)) begin
                            o_evt.done = 1'b1;
                            n_phase    = lcar_pkg::PH_IDLE;
                            n_edge     = '0;
                            n_shift    = '0;
                        end
                    end
                end
                default: begin
                    n_phase = lcar_pkg::PH_IDLE;
                    n_edge  = '0;
                    n_high  = 1'b0;
                    n_shift = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lcar_pkg::PH_IDLE;
            r_edge  <= '0;
            r_high  <= 1'b0;
            r_shift <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_edge  <= n_edge;
            r_high  <= n_high;
            r_shift <= n_shift;
        end
    end

endmodule

@@ hdl/lcar_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_div
// Bit-serial restoring divider: sample sum over sample count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module lcar_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lcar_pkg::SUM_BITS-1:0]   i_dividend,
    input  logic [lcar_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                            o_done,
    output logic [lcar_pkg::SAMPLE_BITS-1:0] o_quotient
);

    logic                              r_busy, r_done;
    logic [lcar_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [lcar_pkg::SUM_BITS-1:0]     r_quo, n_quo;
    logic [lcar_pkg::COUNT_BITS-1:0]   r_rem, n_rem;
    logic [lcar_pkg::COUNT_BITS-1:0]   r_div;
    logic [lcar_pkg::COUNT_BITS:0]     w_rem_sh, w_diff;
    logic                              w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[lcar_pkg::SUM_BITS-1]};
        w_ge     = w_rem_sh >= {1'b0, r_div};
        w_diff   = w_rem_sh - {1'b0, r_div};
        n_rem    = w_ge ? w_diff[lcar_pkg::COUNT_BITS-1:0]
                        : w_rem_sh[lcar_pkg::COUNT_BITS-1:0];
        n_quo    = {r_quo[lcar_pkg::SUM_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + lcar_pkg::DIV_CNT_BITS'(1);
                if (r_cnt == lcar_pkg::DIV_CNT_BITS'(lcar_pkg::SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[lcar_pkg::SAMPLE_BITS-1:0];

endmodule

@@ hdl/lcar_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_mul
// Shift-add multiplier: offset-corrected magnitude times inverse scale,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lcar_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lcar_pkg::SAMPLE_BITS-1:0] i_mag,
    input  logic [lcar_pkg::SCALE_BITS-1:0]  i_scale,
    output logic                             o_done,
    output logic [lcar_pkg::PROD_BITS-1:0]   o_product
);

    logic                              r_busy, r_done;
    logic [lcar_pkg::MUL_CNT_BITS-1:0] r_cnt;
    logic [lcar_pkg::SCALE_BITS-1:0]   r_hi;
    logic [lcar_pkg::SAMPLE_BITS-1:0]  r_lo;
    logic [lcar_pkg::SCALE_BITS:0]     w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, i_scale} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + lcar_pkg::MUL_CNT_BITS'(1);
                if (r_cnt == lcar_pkg::MUL_CNT_BITS'(lcar_pkg::SAMPLE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= '0;
            r_lo <= i_mag;
        end else if (r_busy) begin
            r_hi <= w_sum[lcar_pkg::SCALE_BITS:1];
            r_lo <= {w_sum[0], r_lo[lcar_pkg::SAMPLE_BITS-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

@@ hdl/load_cell_adc_reader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Load cell bridge converter reader: serial clock sequencing, averaging,
// tare and scaling to weight. One input word is one serial clock tick.
// ----------------------------------------------------------------------------
// Result word registered in the cycle after the input word is taken; for a
//   word that completes an average, once the divider and multiplier are done.
// Throughput: one word per cycle while the output is not held by back-pressure,
//   but a word completing an average runs the serial divider (32 bit steps)
//   and then the serial multiplier (24 bit steps) before the next word is taken.
// Reset (i_rst_n low, synchronous): link idle, sums cleared, offset 0,
//   tare and first-conversion discard pending, registers at 0/10/65536/0.
// ----------------------------------------------------------------------------
module load_cell_adc_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lcar_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lcar_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] dout_level, [1] tare_request, [7:2] zero
    input  logic [lcar_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] sck_level, [1] sample_valid, [25:2] raw_sample, [26] average_valid,
    // [50:27] average_value, [82:51] weight, [83] tare_done, [87:84] zero
    output logic [lcar_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

    localparam int SB = lcar_pkg::SAMPLE_BITS;
    localparam int QB = lcar_pkg::QUOT_BITS;

    lcar_pkg::t_state                   r_state, n_state;
    logic [1:0]                         r_gain;
    logic [lcar_pkg::COUNT_BITS-1:0]    r_count;
    logic [lcar_pkg::SCALE_BITS-1:0]    r_scale;
    logic                               r_pd;
    logic [lcar_pkg::SUM_BITS-1:0]      r_sum;
    logic [lcar_pkg::COUNT_BITS-1:0]    r_taken;
    logic [SB-1:0]                      r_offset;
    logic                               r_tare_pend;
    logic                               r_discard;
    logic                               r_tare_now;
    logic                               r_neg;
    logic                               r_out_valid;
    logic                               r_o_sck, r_o_sv, r_o_av, r_o_td;
    logic [SB-1:0]                      r_o_raw, r_o_avg;
    logic [lcar_pkg::WEIGHT_BITS-1:0]   r_o_wt;

    lcar_pkg::t_link_evt                w_evt;
    logic                               w_accept, w_keep, w_hit, w_tare_eff;
    logic [lcar_pkg::SUM_BITS-1:0]      w_new_sum;
    logic [lcar_pkg::COUNT_BITS:0]      w_new_taken, w_need;
    logic                               w_div_start, w_div_done;
    logic [SB-1:0]                      w_quot, w_off_eff, w_mag;
    logic                               w_neg;
    logic                               w_mul_start, w_mul_done;
    logic [lcar_pkg::PROD_BITS-1:0]     w_prod;
    logic [QB-1:0]                      w_q_floor, w_q_ceil, w_q_neg;
    logic [lcar_pkg::WEIGHT_BITS-1:0]   w_weight;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_axis_tvalid & s_axis_tready;

    lcar_link u_link (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_accept),
        .i_dout       (s_axis_tdata[0]),
        .i_power_down (r_pd),
        .i_gain       (r_gain),
        .o_evt        (w_evt)
    );

    lcar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_new_sum),
        .i_divisor  (w_new_taken[lcar_pkg::COUNT_BITS-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    lcar_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mag     (w_mag),
        .i_scale   (r_scale),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // sample accumulation at the tick of a conversion
    always_comb begin
        w_keep      = w_evt.done & ~r_discard;
        w_new_sum   = r_sum + lcar_pkg::SUM_BITS'(w_evt.sample);
        w_new_taken = {1'b0, r_taken} + (lcar_pkg::COUNT_BITS + 1)'(1);
        if (r_count == '0) begin
            w_need = (lcar_pkg::COUNT_BITS + 1)'(1);
        end else if (r_count > lcar_pkg::AVERAGE_MAX) begin
            w_need = {1'b0, lcar_pkg::AVERAGE_MAX};
        end else begin
            w_need = {1'b0, r_count};
        end
        w_hit      = w_keep & (w_new_taken >= w_need);
        w_tare_eff = r_tare_pend | s_axis_tdata[1];
    end

    // offset correction and weight saturation
    always_comb begin
        w_off_eff = r_tare_now ? w_quot : r_offset;
        w_neg     = w_quot < w_off_eff;
        w_mag     = w_neg ? (w_off_eff - w_quot) : (w_quot - w_off_eff);
        w_q_floor = w_prod[lcar_pkg::PROD_BITS-1:lcar_pkg::FRAC_BITS];
        w_q_ceil  = w_q_floor + QB'(|w_prod[lcar_pkg::FRAC_BITS-1:0]);
        w_q_neg   = (w_q_ceil > lcar_pkg::Q_NEG_MAX) ? lcar_pkg::Q_NEG_MAX : w_q_ceil;
        if (!r_neg) begin
            w_weight = (w_q_floor > lcar_pkg::Q_POS_MAX)
                     ? lcar_pkg::Q_POS_MAX[lcar_pkg::WEIGHT_BITS-1:0]
                     : w_q_floor[lcar_pkg::WEIGHT_BITS-1:0];
        end else begin
            w_weight = '0 - w_q_neg[lcar_pkg::WEIGHT_BITS-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcar_pkg::ST_IDLE: if (w_accept && w_hit) n_state = lcar_pkg::ST_DIV;
            lcar_pkg::ST_DIV:  if (w_div_done) n_state = lcar_pkg::ST_MUL;
            lcar_pkg::ST_MUL:  if (w_mul_done) n_state = lcar_pkg::ST_IDLE;
            default:           n_state = lcar_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_mul_start   = 1'b0;
        case (r_state)
            lcar_pkg::ST_IDLE: begin
                s_axis_tready = ~r_out_valid | m_axis_tready;
                w_div_start   = w_accept & w_hit;
            end
            lcar_pkg::ST_DIV: w_mul_start = w_div_done;
            lcar_pkg::ST_MUL: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcar_pkg::ST_IDLE;
            r_gain      <= lcar_pkg::GAIN_A128;
            r_count     <= lcar_pkg::AVERAGE_COUNT_RST;
            r_scale     <= lcar_pkg::INVERSE_SCALE_RST;
            r_pd        <= 1'b0;
            r_sum       <= '0;
            r_taken     <= '0;
            r_offset    <= '0;
            r_tare_pend <= 1'b1;
            r_discard   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lcar_pkg::REG_GAIN_SELECT:   r_gain  <= i_cfg_data[1:0];
                    lcar_pkg::REG_AVERAGE_COUNT:
                        r_count <= i_cfg_data[lcar_pkg::COUNT_BITS-1:0];
                    lcar_pkg::REG_INVERSE_SCALE: r_scale <= i_cfg_data;
                    lcar_pkg::REG_POWER_DOWN:    r_pd    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_tare_pend <= w_hit ? 1'b0 : w_tare_eff;
                if (w_evt.done && r_discard) begin
                    r_discard <= 1'b0;
                end
                if (w_hit) begin
                    r_sum   <= '0;
                    r_taken <= '0;
                end else if (w_keep) begin
                    r_sum   <= w_new_sum;
                    r_taken <= w_new_taken[lcar_pkg::COUNT_BITS-1:0];
                end
            end
            if (r_state == lcar_pkg::ST_DIV && w_div_done && r_tare_now) begin
                r_offset <= w_quot;
            end
            if (r_state == lcar_pkg::ST_MUL && w_mul_done) begin
                r_out_valid <= 1'b1;
            end else if (w_accept) begin
                r_out_valid <= ~w_hit;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tare_now <= w_tare_eff;
            r_o_sck    <= w_evt.sck;
            r_o_sv     <= w_keep;
            r_o_raw    <= w_keep ? w_evt.sample : '0;
            r_o_av     <= 1'b0;
            r_o_avg    <= '0;
            r_o_wt     <= '0;
            r_o_td     <= 1'b0;
        end
        if (r_state == lcar_pkg::ST_DIV && w_div_done) begin
            r_neg   <= w_neg;
            r_o_av  <= 1'b1;
            r_o_avg <= w_quot;
            r_o_td  <= r_tare_now;
        end
        if (r_state == lcar_pkg::ST_MUL && w_mul_done) begin
            r_o_wt <= w_weight;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        (lcar_pkg::OUT_DATA_BITS - lcar_pkg::OUT_USED_BITS)'(0),
        r_o_td, r_o_wt, r_o_avg, r_o_av, r_o_raw, r_o_sv, r_o_sck
    };

endmodule
